// ===== rtl/unacked_message_retransmit_table_top_macros.svh =====
`ifndef UNACKED_MESSAGE_RETRANSMIT_TABLE_TOP_MACROS_SVH
`define UNACKED_MESSAGE_RETRANSMIT_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UMRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UMRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/umrt_pkg.sv =====
`timescale 1ns / 1ps
package umrt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned RES_CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned DEST_W   = 48;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TOUT_W   = 8;
  localparam int unsigned TOTAL_W  = 32;

  localparam int unsigned IN_DATA_W  = ID_W + DEST_W + HANDLE_W + LEN_W;
  localparam int unsigned OUT_DATA_W = ID_W + DEST_W + HANDLE_W + LEN_W + TOTAL_W;

  localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SENT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RETX     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK_OK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK_UNK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE_DUE = 3'd5;

  localparam logic [TOUT_W-1:0] TIMEOUT_RST = 8'd4;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [DEST_W-1:0]   dest;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
    logic [TIME_W-1:0]   stamp;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;    // latch payload, rewind index and result count
    logic tick_inc;   // advance seconds count
    logic rd_en;      // read table at next index
    logic rd_last;    // read the last live entry
    logic adv;        // step index
    logic send_do;    // store new entry and emit sent result
    logic full_emit;  // emit table full
    logic ack_move;   // move last entry into matched slot, emit ack removed
    logic ack_miss;   // emit ack unknown
    logic retx_hit;   // restamp entry, queue retransmit result
    logic tick_end;   // flush queued result or emit none due
  } umrt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic id_match;
    logic due;
    logic at_end;
    logic n_last;
    logic pend_valid;
    logic out_free;
  } umrt_sts_t;

endpackage

// ===== rtl/umrt_ctrl.sv =====
`timescale 1ns / 1ps
module umrt_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  input  logic [umrt_pkg::CMD_W-1:0]  command_i,
  input  umrt_pkg::umrt_sts_t         sts_i,
  output logic                        s_ready_o,
  output umrt_pkg::umrt_cmd_t         cmd_o
);
  import umrt_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SEND     = 7'b0000010,
    ST_ACK_CHK  = 7'b0000100,
    ST_ACK_MOVE = 7'b0001000,
    ST_ACK_MISS = 7'b0010000,
    ST_TICK_CHK = 7'b0100000,
    ST_TICK_END = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          case (command_i)
            CMD_SEND: begin
              cmd_o.load_in = 1'b1;
              state_d       = ST_SEND;
            end
            CMD_ACK: begin
              cmd_o.load_in = 1'b1;
              cmd_o.rd_en   = 1'b1;
              state_d       = sts_i.empty ? ST_ACK_MISS : ST_ACK_CHK;
            end
            CMD_TICK: begin
              cmd_o.load_in  = 1'b1;
              cmd_o.tick_inc = 1'b1;
              cmd_o.rd_en    = 1'b1;
              state_d        = sts_i.empty ? ST_TICK_END : ST_TICK_CHK;
            end
            default: ;  // unused command: drop
          endcase
        end
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.full_emit = sts_i.full;
          cmd_o.send_do   = !sts_i.full;
          state_d         = ST_IDLE;
        end
      end
      ST_ACK_CHK: begin
        if (sts_i.id_match) begin
          cmd_o.rd_last = 1'b1;
          state_d       = ST_ACK_MOVE;
        end else if (sts_i.at_end) begin
          state_d = ST_ACK_MISS;
        end else begin
          cmd_o.adv   = 1'b1;
          cmd_o.rd_en = 1'b1;
        end
      end
      ST_ACK_MOVE: begin
        if (sts_i.out_free) begin
          cmd_o.ack_move = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_ACK_MISS: begin
        if (sts_i.out_free) begin
          cmd_o.ack_miss = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_TICK_CHK: begin
        if (sts_i.due) begin
          // hold while an earlier retransmit cannot leave
          if (!sts_i.pend_valid || sts_i.out_free) begin
            cmd_o.retx_hit = 1'b1;
            if (sts_i.at_end || sts_i.n_last) begin
              state_d = ST_TICK_END;
            end else begin
              cmd_o.adv   = 1'b1;
              cmd_o.rd_en = 1'b1;
            end
          end
        end else if (sts_i.at_end) begin
          state_d = ST_TICK_END;
        end else begin
          cmd_o.adv   = 1'b1;
          cmd_o.rd_en = 1'b1;
        end
      end
      ST_TICK_END: begin
        if (sts_i.out_free) begin
          cmd_o.tick_end = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/umrt_dpath.sv =====
`timescale 1ns / 1ps
module umrt_dpath #(
  parameter int unsigned TABLE_DEPTH = umrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  umrt_pkg::umrt_cmd_t               cmd_i,
  output umrt_pkg::umrt_sts_t               sts_o,
  input  logic [umrt_pkg::IN_DATA_W-1:0]    s_tdata_i,
  input  logic                              cfg_we_i,
  input  logic [umrt_pkg::TOUT_W-1:0]       cfg_wdata_i,
  input  logic                              m_tready_i,
  output logic                              m_tvalid_o,
  output logic [umrt_pkg::OUT_DATA_W-1:0]   m_tdata_o,
  output logic [umrt_pkg::KIND_W-1:0]       m_tuser_o,
  output logic                              m_tlast_o
);
  import umrt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  entry_t table_mem [TABLE_DEPTH];
  entry_t rdata_q;

  logic [IW-1:0]        idx_q, idx_d, raddr, waddr;
  logic [CW-1:0]        count_q;
  logic [ID_W-1:0]      next_id_q, id_new;
  logic [TIME_W-1:0]    now_q, age;
  logic [TOTAL_W-1:0]   trans_q, trans_inc;
  logic [TOUT_W-1:0]    timeout_q;
  logic [RES_CNT_W-1:0] n_q;

  logic [ID_W-1:0]      ack_q;
  logic [DEST_W-1:0]    dest_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [LEN_W-1:0]     len_q;

  logic                 pend_valid_q;
  logic [ID_W-1:0]      pend_id_q;
  logic [DEST_W-1:0]    pend_dest_q;
  logic [HANDLE_W-1:0]  pend_handle_q;
  logic [LEN_W-1:0]     pend_len_q;
  logic [TOTAL_W-1:0]   pend_total_q;

  logic                 out_valid_q, out_ld, out_free;
  logic [KIND_W-1:0]    out_kind_q, out_kind_d;
  logic [ID_W-1:0]      out_id_q, out_id_d;
  logic [DEST_W-1:0]    out_dest_q, out_dest_d;
  logic [HANDLE_W-1:0]  out_handle_q, out_handle_d;
  logic [LEN_W-1:0]     out_len_q, out_len_d;
  logic [TOTAL_W-1:0]   out_total_q, out_total_d;
  logic                 out_last_q, out_last_d;

  logic                 we;
  entry_t               wdata;

  assign id_new    = next_id_q + ID_W'(1);
  assign trans_inc = trans_q + TOTAL_W'(1);
  assign age       = now_q - rdata_q.stamp;
  assign out_free  = !out_valid_q || m_tready_i;

  always_comb begin
    if (cmd_i.load_in) begin
      idx_d = '0;
    end else if (cmd_i.adv) begin
      idx_d = idx_q + IW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  assign raddr = cmd_i.rd_last ? IW'(count_q - CW'(1)) : idx_d;

  // Status
  assign sts_o.full       = (count_q == CW'(TABLE_DEPTH));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.id_match   = (rdata_q.id == ack_q);
  assign sts_o.due        = (age >= TIME_W'(timeout_q));
  assign sts_o.at_end     = ((CW'(idx_q) + CW'(1)) == count_q);
  assign sts_o.n_last     = (n_q == RES_CNT_W'(MAX_RESULTS - 1));
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

  // Table write port
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = rdata_q;
    if (cmd_i.send_do) begin
      we    = 1'b1;
      waddr = IW'(count_q);
      wdata = '{id: id_new, dest: dest_q, handle: handle_q, len: len_q, stamp: now_q};
    end else if (cmd_i.ack_move) begin
      we = 1'b1;
    end else if (cmd_i.retx_hit) begin
      we          = 1'b1;
      wdata.stamp = now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en || cmd_i.rd_last) begin
      rdata_q <= table_mem[raddr];
    end
  end

  // Output register load
  always_comb begin
    out_ld       = 1'b0;
    out_kind_d   = KIND_NONE_DUE;
    out_id_d     = '0;
    out_dest_d   = '0;
    out_handle_d = '0;
    out_len_d    = '0;
    out_total_d  = trans_q;
    out_last_d   = 1'b1;
    if (cmd_i.send_do) begin
      out_ld       = 1'b1;
      out_kind_d   = KIND_SENT;
      out_id_d     = id_new;
      out_dest_d   = dest_q;
      out_handle_d = handle_q;
      out_len_d    = len_q;
      out_total_d  = trans_inc;
    end else if (cmd_i.full_emit) begin
      out_ld     = 1'b1;
      out_kind_d = KIND_FULL;
    end else if (cmd_i.ack_move || cmd_i.ack_miss) begin
      out_ld     = 1'b1;
      out_kind_d = cmd_i.ack_move ? KIND_ACK_OK : KIND_ACK_UNK;
      out_id_d   = ack_q;
    end else if ((cmd_i.retx_hit || cmd_i.tick_end) && pend_valid_q) begin
      // release the queued retransmit; it is last only at the end of the scan
      out_ld       = 1'b1;
      out_kind_d   = KIND_RETX;
      out_id_d     = pend_id_q;
      out_dest_d   = pend_dest_q;
      out_handle_d = pend_handle_q;
      out_len_d    = pend_len_q;
      out_total_d  = pend_total_q;
      out_last_d   = cmd_i.tick_end;
    end else if (cmd_i.tick_end) begin
      out_ld = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_kind_q   <= out_kind_d;
      out_id_q     <= out_id_d;
      out_dest_q   <= out_dest_d;
      out_handle_q <= out_handle_d;
      out_len_q    <= out_len_d;
      out_total_q  <= out_total_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ack_q    <= s_tdata_i[0 +: ID_W];
      dest_q   <= s_tdata_i[ID_W +: DEST_W];
      handle_q <= s_tdata_i[ID_W + DEST_W +: HANDLE_W];
      len_q    <= s_tdata_i[ID_W + DEST_W + HANDLE_W +: LEN_W];
    end
    if (cmd_i.retx_hit) begin
      pend_id_q     <= rdata_q.id;
      pend_dest_q   <= rdata_q.dest;
      pend_handle_q <= rdata_q.handle;
      pend_len_q    <= rdata_q.len;
      pend_total_q  <= trans_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      count_q      <= '0;
      next_id_q    <= '0;
      now_q        <= '0;
      trans_q      <= '0;
      timeout_q    <= TIMEOUT_RST;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.tick_inc) begin
        now_q <= now_q + TIME_W'(1);
      end
      if (cmd_i.send_do) begin
        next_id_q <= id_new;
        count_q   <= count_q + CW'(1);
      end else if (cmd_i.ack_move) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.send_do || cmd_i.retx_hit) begin
        trans_q <= trans_inc;
      end
      if (cmd_i.load_in) begin
        n_q <= '0;
      end else if (cmd_i.retx_hit) begin
        n_q <= n_q + RES_CNT_W'(1);
      end
      if (cmd_i.retx_hit) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.tick_end) begin
        pend_valid_q <= 1'b0;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {out_total_q, out_len_q, out_handle_q, out_dest_q, out_id_q};

endmodule

// ===== rtl/unacked_message_retransmit_table_top.sv =====
`timescale 1ns / 1ps
// Channel    Dir  Handshake                Payload
// s_axis     in   tvalid/tready            tuser command; tdata ack, dest, handle, length
// m_axis     out  tvalid/tready, tlast     tuser kind; tdata id, dest, handle, length, total
// cfg        in   cfg_we_i (no wait)       timeout in seconds
//
// A tick scan walks the table one entry a cycle, unless a stall on m_axis holds it, through the
// single read port of the table memory.
// Reset clears counters, the timeout (to 4) and all handshake state; the table needs no clearing.
// A stall on m_axis holds the scan at the next due entry, never dropping a result.
`include "unacked_message_retransmit_table_top_macros.svh"
module unacked_message_retransmit_table_top #(
  parameter int unsigned TABLE_DEPTH = umrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input transfer
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [31:0] ack_id, [79:32] dest_tag, [95:80] msg_handle, [103:96] msg_length
  input  logic [umrt_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // [1:0] command
  input  logic [umrt_pkg::CMD_W-1:0]        s_axis_tuser_i,
  // result transfer
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [31:0] seq_id, [79:32] out_dest, [95:80] out_handle, [103:96] out_length,
  // [135:104] transmit_total
  output logic [umrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // [2:0] kind
  output logic [umrt_pkg::KIND_W-1:0]       m_axis_tuser_o,
  output logic                              m_axis_tlast_o,
  // timeout register
  input  logic                              cfg_we_i,
  input  logic [umrt_pkg::TOUT_W-1:0]       cfg_wdata_i
);
  import umrt_pkg::*;

  umrt_cmd_t cmd;
  umrt_sts_t sts;

  // Sequence one item at a time: accept, walk the table, emit results.
  umrt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .command_i (s_axis_tuser_i),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready_o),
    .cmd_o     (cmd)
  );

  // Table memory, counters, timeout register and output register.
  umrt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

  // Only retransmits may come as non-final results of an item.
  `UMRT_ASSERT_IMP(a_single_final, m_axis_tvalid_o && (m_axis_tuser_o != KIND_RETX), m_axis_tlast_o, "non-retransmit result without tlast")
  // A queued retransmit never survives into the idle state.
  `UMRT_ASSERT_IMP(a_idle_no_pend, s_axis_tready_o, !sts.pend_valid, "retransmit left queued after tick")
  // A tick transfer always takes the block out of idle.
  `UMRT_ASSERT_NXT(a_tick_busy, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == CMD_TICK), !s_axis_tready_o, "tick accepted without starting a scan")

endmodule

// ===== tb/sv/unacked_message_retransmit_table_top_tb.sv =====
`timescale 1ns / 1ps
module unacked_message_retransmit_table_top_tb;
  import umrt_pkg::*;

  localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
  localparam int unsigned DEST_LSB    = ID_W;
  localparam int unsigned HANDLE_LSB  = DEST_LSB + DEST_W;
  localparam int unsigned LEN_LSB     = HANDLE_LSB + HANDLE_W;
  localparam int unsigned TOTAL_LSB   = LEN_LSB + LEN_W;
  // Command 3 has no meaning: the block takes it and reports nothing.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // An ack or a tick walks at most the whole table.
  localparam int CFG_SETTLE   = 40;
  localparam int END_SETTLE   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int REPORT_LIMIT = 10;

  // One result transfer, split into its fields.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     seq_id;
    logic [DEST_W-1:0]   dest;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
    logic [TOTAL_W-1:0]  total;
    logic                last;
  } link_result_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid   = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata    = '0;
  logic [CMD_W-1:0]      s_axis_tuser    = CMD_SEND;
  logic                  m_axis_tready   = 1'b0;
  logic                  cfg_we          = 1'b0;
  logic [TOUT_W-1:0]     cfg_wdata       = TIMEOUT_RST;

  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [KIND_W-1:0]     m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  // Shadow of the unacknowledged table and the link counters.
  entry_t                shadow_table [DEPTH];
  int                    live_count  = 0;
  logic [ID_W-1:0]       next_id     = '0;
  logic [TIME_W-1:0]     now_sec     = '0;
  logic [TOTAL_W-1:0]    tx_total    = '0;
  logic [TOUT_W-1:0]     timeout_cfg = TIMEOUT_RST;

  // Results owed by the block, oldest first.
  link_result_t          awaited_results [$];
  link_result_t          batch_q [$];

  // Traffic shaping: idle odds in percent and a long receiver hold-off.
  int                    tx_idle_pct = 0;
  int                    rx_idle_pct = 0;
  int                    rx_hold_req = 0;
  int                    rx_hold_left = 0;

  int                    err_count      = 0;
  int                    items_accepted = 0;
  int                    results_seen   = 0;
  int                    kind_seen [8];

  unacked_message_retransmit_table_top #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still owed", CYCLE_LIMIT,
             awaited_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] pack_input(input logic [ID_W-1:0] ack,
                                                      input logic [DEST_W-1:0] dest,
                                                      input logic [HANDLE_W-1:0] handle,
                                                      input logic [LEN_W-1:0] len);
    return {len, handle, dest, ack};
  endfunction

  function automatic void queue_result(input logic [KIND_W-1:0] kind,
                                       input logic [ID_W-1:0] id, input entry_t msg);
    link_result_t r;
    r.kind   = kind;
    r.seq_id = id;
    r.dest   = msg.dest;
    r.handle = msg.handle;
    r.len    = msg.len;
    r.total  = tx_total;
    r.last   = 1'b0;
    batch_q.push_back(r);
  endfunction

  // Advance the shadow table by one accepted command and queue what it owes.
  task automatic advance_link_state(input logic [CMD_W-1:0] cmd,
                                    input logic [IN_DATA_W-1:0] data);
    entry_t            incoming;
    entry_t            blank;
    logic [ID_W-1:0]   ack;
    logic [TIME_W-1:0] age;
    link_result_t      r;
    int                slot;
    blank           = '0;
    ack             = data[ID_W-1:0];
    incoming        = '0;
    incoming.dest   = data[DEST_LSB +: DEST_W];
    incoming.handle = data[HANDLE_LSB +: HANDLE_W];
    incoming.len    = data[LEN_LSB +: LEN_W];
    batch_q.delete();
    case (cmd)
      CMD_SEND: begin
        // A full table flags the send and consumes no id.
        if (live_count >= DEPTH) begin
          queue_result(KIND_FULL, '0, blank);
        end else begin
          next_id = next_id + 1'b1;
          incoming.id    = next_id;
          incoming.stamp = now_sec;
          shadow_table[live_count] = incoming;
          live_count++;
          tx_total = tx_total + 1'b1;
          queue_result(KIND_SENT, next_id, incoming);
        end
      end
      CMD_ACK: begin
        // First match wins; the last live entry fills the hole.
        slot = -1;
        for (int i = 0; i < live_count; i++) begin
          if (slot < 0 && shadow_table[i].id == ack) slot = i;
        end
        if (slot >= 0) begin
          shadow_table[slot] = shadow_table[live_count - 1];
          live_count--;
          queue_result(KIND_ACK_OK, ack, blank);
        end else begin
          queue_result(KIND_ACK_UNK, ack, blank);
        end
      end
      CMD_TICK: begin
        now_sec = now_sec + 1'b1;
        for (int i = 0; i < live_count && batch_q.size() < MAX_RESULTS; i++) begin
          age = now_sec - shadow_table[i].stamp;
          if (age >= timeout_cfg) begin
            shadow_table[i].stamp = now_sec;
            tx_total = tx_total + 1'b1;
            queue_result(KIND_RETX, shadow_table[i].id, shadow_table[i]);
          end
        end
        if (batch_q.size() == 0) queue_result(KIND_NONE_DUE, '0, blank);
      end
      default: ;
    endcase
    if (batch_q.size() != 0) begin
      r = batch_q.pop_back();
      r.last = 1'b1;
      batch_q.push_back(r);
    end
    foreach (batch_q[k]) awaited_results.push_back(batch_q[k]);
  endtask

  // Check each result transfer against the oldest owed one, then predict from the
  // input transfer of the same edge. Both are sampled on the rising edge.
  always @(posedge clk_i) begin : track_link
    link_result_t want;
    link_result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready) begin
        got.kind   = m_axis_tuser_o;
        got.seq_id = m_axis_tdata_o[ID_W-1:0];
        got.dest   = m_axis_tdata_o[DEST_LSB +: DEST_W];
        got.handle = m_axis_tdata_o[HANDLE_LSB +: HANDLE_W];
        got.len    = m_axis_tdata_o[LEN_LSB +: LEN_W];
        got.total  = m_axis_tdata_o[TOTAL_LSB +: TOTAL_W];
        got.last   = m_axis_tlast_o;
        results_seen++;
        kind_seen[got.kind]++;
        if (awaited_results.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("%t unexpected result: kind %0d id %h total %h last %b", $realtime,
                     got.kind, got.seq_id, got.total, got.last);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= REPORT_LIMIT) begin
              $display("%t result mismatch", $realtime);
              $display("  want kind %0d id %h dest %h hdl %h len %h total %h last %b",
                       want.kind, want.seq_id, want.dest, want.handle, want.len,
                       want.total, want.last);
              $display("  got  kind %0d id %h dest %h hdl %h len %h total %h last %b",
                       got.kind, got.seq_id, got.dest, got.handle, got.len,
                       got.total, got.last);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready_o) begin
        items_accepted++;
        advance_link_state(s_axis_tuser, s_axis_tdata);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      m_axis_tready = 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one item, after random idle cycles, and hold it until accepted.
  // Entered and left just after a falling edge; tvalid stays high on return.
  task automatic transfer_item(input logic [CMD_W-1:0] cmd,
                               input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic wait_drain();
    s_axis_tvalid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
  endtask

  // Write the timeout only once the block is idle again.
  task automatic write_timeout(input logic [TOUT_W-1:0] value);
    wait_drain();
    repeat (CFG_SETTLE) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we      = 1'b0;
    timeout_cfg = value;
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Mostly well-formed traffic: sends, acks of live ids and ticks; the rest is
  // acks of random ids and unused commands. Unused fields carry noise.
  task automatic send_random_item();
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  ack;
    logic [31:0]      w0;
    logic [31:0]      w1;
    logic [31:0]      w2;
    int               pick;
    pick = $urandom_range(0, 99);
    ack  = $urandom;
    w0   = $urandom;
    w1   = $urandom;
    w2   = $urandom;
    if (pick < 42) begin
      cmd = CMD_SEND;
    end else if (pick < 66) begin
      cmd = CMD_ACK;
      if (live_count > 0) ack = shadow_table[$urandom_range(0, live_count - 1)].id;
    end else if (pick < 74) begin
      cmd = CMD_ACK;
    end else if (pick < 96) begin
      cmd = CMD_TICK;
    end else begin
      cmd = CMD_UNUSED;
    end
    transfer_item(cmd, pack_input(ack, {w1[15:0], w0}, w2[15:0], w2[23:16]));
  endtask

  // Default timeout: field extremes, known and unknown acks, ticks up to the
  // first retransmit, and an unused command.
  task automatic test_basic_commands();
    transfer_item(CMD_SEND, pack_input('0, '0, '0, '0));
    transfer_item(CMD_SEND, pack_input('1, '1, '1, '1));
    transfer_item(CMD_SEND, pack_input(32'h1234_5678, 48'ha5a5_0f0f_3c3c, 16'h5a5a, 8'h80));
    transfer_item(CMD_ACK, pack_input('0, '0, '0, '0));
    transfer_item(CMD_ACK, pack_input('1, '1, '1, '1));
    transfer_item(CMD_ACK, pack_input(32'd2, '0, '0, '0));
    transfer_item(CMD_ACK, pack_input(32'd2, '1, '1, '1));
    repeat (4) transfer_item(CMD_TICK, pack_input('0, '0, '0, '0));
    transfer_item(CMD_UNUSED, pack_input('1, '1, '1, '1));
    transfer_item(CMD_TICK, pack_input('1, '1, '1, '1));
    transfer_item(CMD_ACK, pack_input(32'd1, '0, '0, '0));
  endtask

  // Fill the table, overflow it once, then make every entry due on one tick.
  task automatic test_table_full();
    logic [31:0] w0;
    logic [31:0] w1;
    while (live_count < DEPTH) begin
      w0 = $urandom;
      w1 = $urandom;
      transfer_item(CMD_SEND, pack_input('0, {w1[15:0], w0}, w1[31:16], w0[7:0]));
    end
    transfer_item(CMD_SEND, pack_input('0, '1, '1, '1));
    write_timeout(8'd0);
    transfer_item(CMD_TICK, pack_input('0, '0, '0, '0));
  endtask

  // Hold the receiver off while ticks and sends keep coming, so the block
  // backs up and stalls its input; then pause until everything has drained.
  task automatic test_backpressure();
    wait_drain();
    @(posedge clk_i);
    rx_hold_req = HOLD_CYCLES;
    @(negedge clk_i);
    repeat (30) send_random_item();
    wait_drain();
  endtask

  task automatic test_random_traffic(input int count, input logic [TOUT_W-1:0] timeout);
    write_timeout(timeout);
    repeat (count) send_random_item();
  endtask

  initial begin
    foreach (kind_seen[k]) kind_seen[k] = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_idle(19, 63);
    test_basic_commands();
    test_table_full();
    test_backpressure();
    test_random_traffic(110, 8'd3);

    set_idle(63, 19);
    test_random_traffic(110, 8'd1);

    set_idle(0, 0);
    test_random_traffic(50, 8'd0);
    test_random_traffic(30, 8'd255);

    wait_drain();
    repeat (END_SETTLE) @(negedge clk_i);

    $display("covered %0d commands and %0d results over timeouts 4, 0, 3, 1 and 255",
             items_accepted, results_seen);
    $display("sent %0d, retransmitted %0d, acked %0d, unknown acks %0d, full %0d, idle ticks %0d",
             kind_seen[KIND_SENT], kind_seen[KIND_RETX], kind_seen[KIND_ACK_OK],
             kind_seen[KIND_ACK_UNK], kind_seen[KIND_FULL], kind_seen[KIND_NONE_DUE]);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures, %0d results never arrived", err_count, awaited_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/umrt_pkg.sv
rtl/umrt_ctrl.sv
rtl/umrt_dpath.sv
rtl/unacked_message_retransmit_table_top.sv
tb/sv/unacked_message_retransmit_table_top_tb.sv
